@@ sv/gpe_pkg.sv @@
// ----------------------------------------------------------------------------
// gpe_pkg
// Shared types, register indexes and the hex digit font for the glyph
// pixel expander.
// ----------------------------------------------------------------------------
package gpe_pkg;

    // Largest frame dimension honored for clipping and indexing.
    localparam logic [12:0] MAX_DIM = 13'd4096;

    // Configuration register indexes.
    localparam logic REG_FRAME_WIDTH  = 1'b0;
    localparam logic REG_FRAME_HEIGHT = 1'b1;

    // Draw commands.
    localparam logic CMD_GLYPH = 1'b0;
    localparam logic CMD_HEX   = 1'b1;

    // Dense 4x8 hex digit font, one nibble per row, row 0 in the low nibble.
    localparam logic [31:0] DIGIT_FONT [16] = '{
        32'h07555700, 32'h06222700, 32'h07174700, 32'h07171700,
        32'h05571100, 32'h07471700, 32'h07475700, 32'h07111100,
        32'h07575700, 32'h07571100, 32'h02575500, 32'h06565600,
        32'h03444300, 32'h06555600, 32'h07474700, 32'h07474400
    };

    // One pixel selected by the scanner in a given cycle.
    typedef struct packed {
        logic       valid;
        logic       last;
        logic [2:0] row;
        logic [2:0] col;
    } emit_t;

    // Builds an 8x8 bitmap showing a byte as two hex digits side by side.
    function automatic logic [63:0] hex_bitmap(input logic [7:0] value);
        logic [31:0] hi_glyph;
        logic [31:0] lo_glyph;
        logic [63:0] pix;
        hi_glyph = DIGIT_FONT[value[7:4]];
        lo_glyph = DIGIT_FONT[value[3:0]];
        pix      = '0;
        for (int r = 0; r < 8; r++)
        begin
            pix[r*8+4 +: 4] = hi_glyph[r*4 +: 4];
            pix[r*8   +: 4] = lo_glyph[r*4 +: 4];
        end
        return pix;
    endfunction

endpackage

@@ sv/glyph_pixel_expander_unit.sv @@
// ----------------------------------------------------------------------------
// glyph_pixel_expander_unit
// Expands one 8x8 glyph draw request into clipped pixel writes.
//
// A request is transferred at a rising edge where start is high and busy is
// low. cmd selects raw glyph_bits or hex_byte drawn as two hex digits.
// Sixteen clipping lanes (eight columns, eight rows) check the cell against
// the frame in the transfer cycle, and the visible-pixel mask is stored in
// a one-entry request buffer. The scanner then emits one pixel per cycle,
// rows top to bottom, columns left to right, followed by a three-stage
// pipeline (coordinates, multiply, then add). Each pixel write is on the
// output ports for exactly one cycle with strobe high; last marks the final
// write of a request. The receiver cannot stall the outputs.
// With the scanner idle, a request moves from the request buffer into the
// scanner and then through the coordinate, multiply and add stages to the
// outputs. Throughput: one pixel per cycle; the scanner is the limit. A
// request has at most 64 visible pixels; one with none gives no write.
// The next request can be transferred while the previous one is scanned.
// Reset sets the frame to 640 x 480 and discards any work in flight.
// Frame registers are written through wr_en, wr_index and wr_data.
// ----------------------------------------------------------------------------
module glyph_pixel_expander_unit (
    input  logic               clk,
    input  logic               rst_n,
    // Configuration write port
    input  logic               wr_en,
    input  logic               wr_index,
    input  logic [12:0]        wr_data,
    // Request channel
    input  logic               start,
    output logic               busy,
    input  logic               cmd,
    input  logic [63:0]        glyph_bits,
    input  logic [7:0]         hex_byte,
    input  logic signed [13:0] x_origin,
    input  logic signed [13:0] y_origin,
    input  logic [23:0]        pen_color,
    // Pixel write channel
    output logic               strobe,
    output logic [11:0]        pixel_x,
    output logic [11:0]        pixel_y,
    output logic [23:0]        pixel_index,
    output logic [7:0]         red,
    output logic [7:0]         green,
    output logic [7:0]         blue,
    output logic               last
);
    import gpe_pkg::*;

    // Configuration registers
    logic [12:0] frame_width_reg;
    logic [12:0] frame_height_reg;
    logic [12:0] width_lim;
    logic [12:0] height_lim;

    // Request buffer
    logic               pend_valid_reg;
    logic               pend_valid_next;
    logic [63:0]        pend_mask_reg;
    logic signed [13:0] pend_x_reg;
    logic signed [13:0] pend_y_reg;
    logic [23:0]        pend_color_reg;

    // Fields of the glyph being scanned
    logic signed [13:0] cur_x_reg;
    logic signed [13:0] cur_y_reg;
    logic [23:0]        cur_color_reg;

    // Lane and merge signals
    logic        accept;
    logic        take;
    logic        load;
    logic [63:0] pix;
    logic [7:0]  col_ok;
    logic [7:0]  row_ok;
    logic [63:0] vis_mask;
    emit_t       emit;

    // Pipeline after the scanner
    logic        e1_valid_reg;
    logic        e1_last_reg;
    logic [11:0] e1_x_reg;
    logic [11:0] e1_y_reg;
    logic [23:0] e1_color_reg;
    logic [14:0] e1_x_sum;
    logic [14:0] e1_y_sum;
    logic        e2_valid_reg;
    logic        e2_last_reg;
    logic [11:0] e2_x_reg;
    logic [11:0] e2_y_reg;
    logic [23:0] e2_color_reg;
    logic [24:0] e2_prod;
    logic [23:0] e2_prod_reg;
    logic        out_valid_reg;
    logic        out_last_reg;
    logic [11:0] out_x_reg;
    logic [11:0] out_y_reg;
    logic [23:0] out_index_reg;
    logic [23:0] out_color_reg;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= 13'd640;
            frame_height_reg <= 13'd480;
        end
        else if (wr_en)
        begin
            case (wr_index)
                REG_FRAME_WIDTH:  frame_width_reg  <= wr_data;
                REG_FRAME_HEIGHT: frame_height_reg <= wr_data;
                default:          ;
            endcase
        end
    end

    // Oversized frames are treated as the largest supported frame.
    assign width_lim  = (frame_width_reg  > MAX_DIM) ? MAX_DIM : frame_width_reg;
    assign height_lim = (frame_height_reg > MAX_DIM) ? MAX_DIM : frame_height_reg;

    // Handshake: the buffer frees up in the cycle the scanner takes its content.
    assign busy   = pend_valid_reg && !take;
    assign accept = start && !busy;
    assign load   = pend_valid_reg && take;
    assign pend_valid_next = accept || (pend_valid_reg && !take);

    // Source bitmap.
    assign pix = (cmd == CMD_HEX) ? hex_bitmap(hex_byte) : glyph_bits;

    // Clipping lanes, one per column and one per row of the cell.
    for (genvar g = 0; g < 8; g++)
    begin : g_lane
        gpe_lane u_col_lane (
            .origin   (x_origin),
            .offset   (3'(g)),
            .limit    (width_lim),
            .in_range (col_ok[g])
        );
        gpe_lane u_row_lane (
            .origin   (y_origin),
            .offset   (3'(g)),
            .limit    (height_lim),
            .in_range (row_ok[g])
        );
    end

    // Merge the lanes with the bitmap into a scan-order mask (bit row*8+col).
    always_comb
    begin
        for (int r = 0; r < 8; r++)
        begin
            for (int c = 0; c < 8; c++)
            begin
                vis_mask[r*8+c] = pix[r*8+7-c] & row_ok[r] & col_ok[c];
            end
        end
    end

    // Request buffer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            pend_valid_reg <= pend_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pend_mask_reg  <= vis_mask;
            pend_x_reg     <= x_origin;
            pend_y_reg     <= y_origin;
            pend_color_reg <= pen_color;
        end
        if (load)
        begin
            cur_x_reg     <= pend_x_reg;
            cur_y_reg     <= pend_y_reg;
            cur_color_reg <= pend_color_reg;
        end
    end

    gpe_scan u_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (load),
        .load_mask (pend_mask_reg),
        .take      (take),
        .emit      (emit)
    );

    // Stage 1: absolute coordinates of the selected pixel.
    assign e1_x_sum = {cur_x_reg[13], cur_x_reg} + {12'b0, emit.col};
    assign e1_y_sum = {cur_y_reg[13], cur_y_reg} + {12'b0, emit.row};

    // Stage 2: row times frame width.
    assign e2_prod = e1_y_reg * width_lim;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e1_valid_reg  <= 1'b0;
            e2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            e1_valid_reg  <= emit.valid;
            e2_valid_reg  <= e1_valid_reg;
            out_valid_reg <= e2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        e1_last_reg   <= emit.last;
        e1_x_reg      <= e1_x_sum[11:0];
        e1_y_reg      <= e1_y_sum[11:0];
        e1_color_reg  <= cur_color_reg;

        e2_last_reg   <= e1_last_reg;
        e2_x_reg      <= e1_x_reg;
        e2_y_reg      <= e1_y_reg;
        e2_color_reg  <= e1_color_reg;
        e2_prod_reg   <= e2_prod[23:0];

        // Stage 3: add the column to form the linear index.
        out_last_reg  <= e2_last_reg;
        out_x_reg     <= e2_x_reg;
        out_y_reg     <= e2_y_reg;
        out_color_reg <= e2_color_reg;
        out_index_reg <= e2_prod_reg + {12'b0, e2_x_reg};
    end

    // Output drive.
    assign strobe      = out_valid_reg;
    assign last        = out_last_reg;
    assign pixel_x     = out_x_reg;
    assign pixel_y     = out_y_reg;
    assign pixel_index = out_index_reg;
    assign red         = out_color_reg[23:16];
    assign green       = out_color_reg[15:8];
    assign blue        = out_color_reg[7:0];

    // A selected pixel in stage 1 passes through stages 2 and 3 to the outputs.
    assert property (@(posedge clk) disable iff (!rst_n)
        e1_valid_reg |-> ##2 strobe)
        else $error("pixel lost in the index pipeline");

    // Writes of one request come in consecutive cycles.
    assert property (@(posedge clk) disable iff (!rst_n)
        strobe && !last |=> strobe)
        else $error("gap inside the writes of one request");

    // Holding off requests only happens while a glyph is being scanned.
    assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> emit.valid)
        else $error("busy while the scanner is idle");

endmodule

@@ sv/gpe_lane.sv @@
// ----------------------------------------------------------------------------
// gpe_lane
// One clipping lane: checks whether origin plus a cell offset lies inside
// the range zero up to (not including) the frame limit.
// ----------------------------------------------------------------------------
module gpe_lane (
    input  logic signed [13:0] origin,
    input  logic        [2:0]  offset,
    input  logic        [12:0] limit,
    output logic               in_range
);
    logic [14:0] coord;

    // Sign-extended sum; a set top bit means the coordinate is negative.
    assign coord    = {origin[13], origin} + {12'b0, offset};
    assign in_range = !coord[14] && (coord[13:0] < {1'b0, limit});

endmodule

@@ sv/gpe_scan.sv @@
// ----------------------------------------------------------------------------
// gpe_scan
// Pixel scanner: holds the visible-pixel mask of the current glyph and picks
// one pixel per cycle in row-major, left-to-right order.
// ----------------------------------------------------------------------------
module gpe_scan (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 load,
    input  logic [63:0]          load_mask,
    output logic                 take,
    output gpe_pkg::emit_t       emit
);
    import gpe_pkg::*;

    logic [63:0] mask_reg;
    logic [63:0] mask_next;
    logic [63:0] first_hit;
    logic [63:0] remaining;
    logic [5:0]  hit_index;

    // Isolate the lowest set bit, which is the next pixel in scan order.
    assign first_hit = mask_reg & (~mask_reg + 64'd1);
    assign remaining = mask_reg & ~first_hit;

    always_comb
    begin
        hit_index = '0;
        for (int i = 0; i < 64; i++)
        begin
            if (first_hit[i])
            begin
                hit_index = hit_index | i[5:0];
            end
        end
    end

    // The scanner takes a new glyph once the current one has at most one pixel left.
    assign take       = (remaining == '0);
    assign emit.valid = (mask_reg != '0);
    assign emit.last  = take;
    assign emit.row   = hit_index[5:3];
    assign emit.col   = hit_index[2:0];

    assign mask_next = load ? load_mask : remaining;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg <= '0;
        end
        else
        begin
            mask_reg <= mask_next;
        end
    end

    // A glyph that is not finished keeps producing a pixel every cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        emit.valid && !take |=> emit.valid)
        else $error("scanner stopped before the glyph was finished");

    // Exactly one pixel is selected whenever the mask is not empty.
    assert property (@(posedge clk) disable iff (!rst_n)
        emit.valid |-> $onehot(first_hit))
        else $error("scanner selected other than one pixel");

endmodule
